/* rtl/assert_macros.svh */
// assertion macros for the rtl of the srgb to ictcp converter
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define A_COMB(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define A_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define A_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define A_COMB(label, clk, rstn, expr)
`define A_IMPL(label, clk, rstn, ante, cons)
`define A_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* rtl/s2ih_pkg.sv */
// types, matrix coefficients and rom builder functions for the srgb to ictcp converter
// no dependencies
`timescale 1ns / 1ps
package s2ih_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] intensity;
    logic [15:0] tritan;
    logic [15:0] protan;
  } pix_out_t;

  // advance strobes for the two stages of an oetf lane
  typedef struct packed {
    logic rd;
    logic ip;
  } oetf_en_t;

  localparam int LIN_ENTRIES = 256;

  // rgb to lms, /4096
  localparam int C_L_R = 1688;
  localparam int C_L_G = 2146;
  localparam int C_L_B = 262;
  localparam int C_M_R = 683;
  localparam int C_M_G = 2951;
  localparam int C_M_B = 462;
  localparam int C_S_R = 99;
  localparam int C_S_G = 309;
  localparam int C_S_B = 3688;
  localparam int MAT_SHIFT = 12;

  // lms' to ictcp, /4096
  localparam int C_I_L  = 2048;
  localparam int C_I_M  = 2048;
  localparam int C_CT_L = 3625;
  localparam int C_CT_M = 7465;
  localparam int C_CT_S = 3840;
  localparam int C_CP_L = 9500;
  localparam int C_CP_M = 9212;
  localparam int C_CP_S = 288;

  localparam int Q88_MAX    = 65280;
  localparam int Q88_OFFSET = 32640;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  // hlg constant c in q30
  localparam longint HLG_C_Q30 = longint'((64'd55991073 << 30) / 64'd100000000);

  // shift and subtract quotient, d well below 2^63
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'd1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned div_frac30(longint unsigned r_in,
                                                 longint unsigned d);
    longint unsigned r;
    longint unsigned q;
    r = r_in;
    q = 0;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint log2_q30(longint unsigned n_in, longint unsigned d_in);
    longint e;
    longint unsigned n;
    longint unsigned d;
    longint unsigned m;
    longint unsigned res;
    e = 0;
    n = n_in;
    d = d_in;
    res = 0;
    while (n >= (d << 1)) begin
      d = d << 1;
      e = e + 1;
    end
    while (n < d) begin
      n = n << 1;
      e = e - 1;
    end
    m = Q30_ONE + div_frac30(n - d, d);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      res = res << 1;
      if (m >= (Q30_ONE << 1)) begin
        m = m >> 1;
        res = res | 64'd1;
      end
    end
    return e * longint'(Q30_ONE) + longint'(res);
  endfunction

  function automatic longint unsigned exp_series_q30(longint unsigned t);
    longint unsigned sum;
    longint unsigned term;
    sum = Q30_ONE;
    term = Q30_ONE;
    for (longint unsigned k = 1; k <= 20; k++) begin
      term = udiv64((term * t) >> 30, k);
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic longint unsigned exp2_neg_to_frac(longint unsigned p, int fb);
    longint unsigned ip;
    longint unsigned fp;
    longint unsigned f;
    longint unsigned s;
    longint unsigned sh;
    ip = p >> 30;
    fp = p & (Q30_ONE - 64'd1);
    f = 0;
    if (fp != 0) begin
      ip = ip + 1;
      f = Q30_ONE - fp;
    end
    s = exp_series_q30((f * LN2_Q30) >> 30);
    sh = 64'd30 + ip;
    if (sh > 62) return 0;
    return ((s << fb) + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic longint unsigned isqrt_round(longint unsigned n);
    longint unsigned x;
    longint unsigned res;
    longint unsigned b;
    x = n;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    if (n - res * res > res) res = res + 1;
    return res;
  endfunction

  // srgb curve, linear light with fb fraction bits
  function automatic longint unsigned lin_entry(int v, int fb);
    longint unsigned num;
    longint l;
    longint unsigned p;
    if (v <= 10) begin
      num = (longint'(v) * 100) << fb;
      return (2 * num + 64'd329460) / 64'd658920;
    end
    l = log2_q30(64'd1000 * longint'(v) + 64'd14025, 64'd269025);
    p = (longint'(-l) * 64'd12) / 64'd5;
    return exp2_neg_to_frac(p, fb);
  endfunction

  // hlg oetf sampled at i / 2^kb
  function automatic longint unsigned oetf_entry(int i, int kb, int fb);
    longint unsigned n;
    longint unsigned d;
    longint l2;
    longint prod;
    longint ln;
    longint val;
    if (64'd12 * longint'(i) <= (64'd1 << kb)) begin
      n = (64'd3 * longint'(i)) << (2 * fb - kb);
      return isqrt_round(n);
    end
    n = 64'd1200000000 * longint'(i) - (64'd28466892 << kb);
    d = 64'd100000000 << kb;
    l2 = log2_q30(n, d);
    // log2 to ln, truncated towards zero
    prod = l2 * longint'(LN2_Q30);
    ln = (prod < 0) ? -((-prod) >>> 30) : (prod >>> 30);
    val = (ln * 64'sd17883277) / 64'sd100000000 + HLG_C_Q30;
    if (val < 0) val = 0;
    return ((longint'(val) << fb) + (Q30_ONE >> 1)) >> 30;
  endfunction

endpackage

/* rtl/s2ih_oetf.sv */
// one hlg oetf lane: rom lookup of two neighbouring samples, then linear interpolation
// depends on s2ih_pkg
`timescale 1ns / 1ps
module s2ih_oetf #(
  parameter int OETF_INDEX_BITS = 10,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  s2ih_pkg::oetf_en_t     en,
  input  logic [FRAC_BITS:0]     lin_val,
  output logic [FRAC_BITS:0]     oetf_val
);
  import s2ih_pkg::*;

  localparam int K     = OETF_INDEX_BITS;
  localparam int F     = FRAC_BITS;
  localparam int VW    = F + 1;
  localparam int DEPTH = (1 << K) + 1;
  localparam logic [K:0] LAST = (K + 1)'(1 << K);
  localparam logic [VW-1:0] ONE = VW'(1) << F;
  localparam logic [2*VW:0] HALF = (2 * VW + 1)'(1) << (F - 1);

  logic [VW-1:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam longint unsigned ENTRY = oetf_entry(i, K, F);
    assign rom[i] = ENTRY[VW-1:0];
  end

  logic [VW+K-1:0] pos;
  logic [K:0]      idx;
  logic            full;
  logic [K:0]      addr0;
  logic [K:0]      addr1;
  logic [F-1:0]    fr;

  assign pos   = {lin_val, {K{1'b0}}};
  assign idx   = pos[VW+K-1:F];
  // full scale reads the last sample with no interpolation
  assign full  = idx[K];
  assign addr0 = full ? LAST : idx;
  assign addr1 = full ? LAST : idx + 1'b1;
  assign fr    = full ? '0 : pos[F-1:0];

  logic [VW-1:0] t0_r;
  logic [VW-1:0] t1_r;
  logic [F-1:0]  fr_r;

  always_ff @(posedge clk) begin
    if (en.rd) begin
      t0_r <= rom[addr0];
      t1_r <= rom[addr1];
      fr_r <= fr;
    end
  end

  logic [VW-1:0]  w0;
  logic [2*VW:0]  acc;
  logic [VW-1:0]  oetf_nxt;
  logic [VW-1:0]  oetf_r;

  assign w0  = ONE - VW'(fr_r);
  assign acc = (2 * VW + 1)'(t0_r * w0) + (2 * VW + 1)'(t1_r * VW'(fr_r)) + HALF;
  assign oetf_nxt = acc[F+VW-1:F];

  always_ff @(posedge clk) begin
    if (en.ip) begin
      oetf_r <= oetf_nxt;
    end
  end

  assign oetf_val = oetf_r;

endmodule

/* rtl/srgb8_to_ictcp_hlg.sv */
// srgb8 pixel to bt.2100 ictcp (hlg) colour converter, six stage pipeline
// depends on s2ih_pkg, s2ih_oetf and assert_macros.svh
//
//  channel | ports                          | payload
//  in      | in_valid, in_stall, in_data    | pix_in_t  red, green, blue
//  out     | out_valid, out_stall, out_data | pix_out_t intensity, tritan, protan
//
// one pixel per clock sustained while out_stall stays low
// stages: srgb rom, lms matrix, oetf rom read, interpolation, ictcp matrix, q8.8 round
// a stage holds while the one after it is full and held, so bubbles close up
// and in_stall rises only when every stage is full and out_stall is high
// synchronous reset clears the valid bits only; no clearing pass
`timescale 1ns / 1ps
module srgb8_to_ictcp_hlg #(
  parameter int OETF_INDEX_BITS = 10,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  s2ih_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output s2ih_pkg::pix_out_t out_data
);
  import s2ih_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int VW = F + 1;
  localparam int SW = VW + MAT_SHIFT + 1;
  localparam int XW = F + 17;
  localparam int NW = XW + 17;
  localparam int QS = F + 12;
  localparam logic [SW-1:0] MAT_HALF = SW'(1) << (MAT_SHIFT - 1);
  localparam logic signed [NW-1:0] OFF_TERM = NW'(Q88_OFFSET) <<< QS;
  localparam logic signed [NW-1:0] HALF_TERM = NW'(1) <<< (QS - 1);

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !out_valid || !out_stall;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) out_valid <= v5_r;
    end
  end

  // stage 1: srgb linearisation
  logic [VW-1:0] lin_tab [LIN_ENTRIES];

  for (genvar v = 0; v < LIN_ENTRIES; v++) begin : g_lin
    localparam longint unsigned ENTRY = lin_entry(v, F);
    assign lin_tab[v] = ENTRY[VW-1:0];
  end

  logic [VW-1:0] lr_r, lg_r, lb_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      lr_r <= lin_tab[in_data.red];
      lg_r <= lin_tab[in_data.green];
      lb_r <= lin_tab[in_data.blue];
    end
  end

  // stage 2: rgb to lms
  logic [SW-1:0] l_sum, m_sum, s_sum;
  logic [VW-1:0] l_r, m_r, s_r;

  assign l_sum = SW'(C_L_R) * SW'(lr_r) + SW'(C_L_G) * SW'(lg_r)
               + SW'(C_L_B) * SW'(lb_r) + MAT_HALF;
  assign m_sum = SW'(C_M_R) * SW'(lr_r) + SW'(C_M_G) * SW'(lg_r)
               + SW'(C_M_B) * SW'(lb_r) + MAT_HALF;
  assign s_sum = SW'(C_S_R) * SW'(lr_r) + SW'(C_S_G) * SW'(lg_r)
               + SW'(C_S_B) * SW'(lb_r) + MAT_HALF;

  always_ff @(posedge clk) begin
    if (en2) begin
      l_r <= l_sum[VW+MAT_SHIFT-1:MAT_SHIFT];
      m_r <= m_sum[VW+MAT_SHIFT-1:MAT_SHIFT];
      s_r <= s_sum[VW+MAT_SHIFT-1:MAT_SHIFT];
    end
  end

  // stages 3 and 4: oetf lanes
  oetf_en_t      oen;
  logic [VW-1:0] lp, mp, sp;

  assign oen.rd = en3;
  assign oen.ip = en4;

  s2ih_oetf #(.OETF_INDEX_BITS(OETF_INDEX_BITS), .FRAC_BITS(FRAC_BITS)) u_oetf_l (
    .clk(clk), .en(oen), .lin_val(l_r), .oetf_val(lp)
  );
  s2ih_oetf #(.OETF_INDEX_BITS(OETF_INDEX_BITS), .FRAC_BITS(FRAC_BITS)) u_oetf_m (
    .clk(clk), .en(oen), .lin_val(m_r), .oetf_val(mp)
  );
  s2ih_oetf #(.OETF_INDEX_BITS(OETF_INDEX_BITS), .FRAC_BITS(FRAC_BITS)) u_oetf_s (
    .clk(clk), .en(oen), .lin_val(s_r), .oetf_val(sp)
  );

  // stage 5: lms' to ictcp
  logic signed [XW-1:0] lps, mps, sps;
  logic signed [XW-1:0] xi_r, xt_r, xp_r;

  assign lps = $signed(XW'(lp));
  assign mps = $signed(XW'(mp));
  assign sps = $signed(XW'(sp));

  always_ff @(posedge clk) begin
    if (en5) begin
      xi_r <= $signed(XW'(C_I_L)) * lps + $signed(XW'(C_I_M)) * mps;
      xt_r <= $signed(XW'(C_CT_L)) * lps - $signed(XW'(C_CT_M)) * mps
            + $signed(XW'(C_CT_S)) * sps;
      xp_r <= $signed(XW'(C_CP_L)) * lps - $signed(XW'(C_CP_M)) * mps
            - $signed(XW'(C_CP_S)) * sps;
    end
  end

  // stage 6: scale by 255 in q8.8, round and saturate
  function automatic logic [15:0] to_q88(logic signed [XW-1:0] x, logic with_off);
    logic signed [NW-1:0] xe;
    logic signed [NW-1:0] num;
    logic [NW-QS-2:0]     q;
    xe  = NW'(x);
    num = (xe <<< 16) - (xe <<< 8) + HALF_TERM + (with_off ? OFF_TERM : '0);
    q   = num[NW-2:QS];
    if (num[NW-1]) return '0;
    if (q > (NW - QS - 1)'(Q88_MAX)) return 16'(Q88_MAX);
    return q[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en6) begin
      out_data.intensity <= to_q88(xi_r, 1'b0);
      out_data.tritan    <= to_q88(xt_r, 1'b1);
      out_data.protan    <= to_q88(xp_r, 1'b1);
    end
  end

`include "assert_macros.svh"

  `A_IMPL(a_stall_only_full, clk, rst_n, in_stall,
          v1_r && v2_r && v3_r && v4_r && v5_r && out_valid && out_stall)
  `A_NEXT(a_in_lands, clk, rst_n, in_valid && !in_stall, v1_r)
  `A_NEXT(a_last_lands, clk, rst_n, v5_r && en6, out_valid)
  `A_COMB(a_out_range, clk, rst_n, !out_valid || (out_data.intensity <= 16'(Q88_MAX)
          && out_data.tritan <= 16'(Q88_MAX) && out_data.protan <= 16'(Q88_MAX)))

endmodule

/* dv/srgb8_to_ictcp_hlg_tb.sv */
// self-checking testbench for srgb8_to_ictcp_hlg: random and directed pixels, checked field by field
// depends on s2ih_pkg for the payload types and matrix coefficients and on the rtl of the converter
`timescale 1ns / 1ps
module srgb8_to_ictcp_hlg_tb;
  import s2ih_pkg::*;

  localparam int IDX_BITS = 10;
  localparam int FB = 16;
  localparam int OETF_LEN = (1 << IDX_BITS) + 1;
  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned LN2_30 = 64'd744261118;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pix_in_t in_data;
  logic out_valid;
  logic out_stall;
  pix_out_t out_data;

  pix_in_t pending_pix[$];
  pix_out_t expected_ictcp[$];
  longint unsigned srgb_lin[256];
  longint unsigned hlg_curve[OETF_LEN];
  int send_idle_pct;
  int recv_stall_pct;
  bit send_hold;
  bit took;
  bit failed;

  srgb8_to_ictcp_hlg DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // log2(n/d) in signed q30
  function automatic longint log2_ratio(longint unsigned n0, longint unsigned d0);
    longint ex;
    longint unsigned n;
    longint unsigned d;
    longint unsigned r;
    longint unsigned m;
    longint unsigned q;
    longint unsigned bits;
    ex = 0;
    n = n0;
    d = d0;
    bits = 0;
    q = 0;
    while (n >= (d << 1)) begin
      d = d << 1;
      ex++;
    end
    while (n < d) begin
      n = n << 1;
      ex--;
    end
    r = n - d;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    m = ONE30 + q;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      bits = bits << 1;
      if (m >= (ONE30 << 1)) begin
        m = m >> 1;
        bits = bits | 64'd1;
      end
    end
    return ex * longint'(ONE30) + longint'(bits);
  endfunction

  // 2^(-p) with p in q30, rounded to FB fraction bits
  function automatic longint unsigned pow2_neg(longint unsigned p);
    longint unsigned whole;
    longint unsigned fr;
    longint unsigned t;
    longint unsigned acc;
    longint unsigned term;
    longint unsigned sh;
    whole = p >> 30;
    fr = p & (ONE30 - 64'd1);
    t = 0;
    if (fr != 0) begin
      whole++;
      t = ONE30 - fr;
    end
    t = (t * LN2_30) >> 30;
    acc = ONE30;
    term = ONE30;
    for (longint unsigned k = 1; k <= 20; k++) begin
      term = ((term * t) >> 30) / k;
      acc = acc + term;
    end
    sh = 64'd30 + whole;
    if (sh > 62) return 0;
    return ((acc << FB) + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic longint unsigned sqrt_rounded(longint unsigned n);
    longint unsigned x;
    longint unsigned r;
    longint unsigned b;
    x = n;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n - r * r > r) r++;
    return r;
  endfunction

  task automatic build_curves();
    longint lg;
    longint lnv;
    longint v;
    longint unsigned n;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        n = (longint'(c) * 100) << FB;
        srgb_lin[c] = (2 * n + 64'd329460) / 64'd658920;
      end else begin
        lg = log2_ratio(64'd1000 * c + 64'd14025, 64'd269025);
        srgb_lin[c] = pow2_neg((longint'(-lg) * 64'd12) / 64'd5);
      end
    end
    for (int i = 0; i < OETF_LEN; i++) begin
      if (64'd12 * i <= (64'd1 << IDX_BITS)) begin
        hlg_curve[i] = sqrt_rounded((64'd3 * i) << (2 * FB - IDX_BITS));
      end else begin
        n = 64'd1200000000 * i - (64'd28466892 << IDX_BITS);
        lg = log2_ratio(n, 64'd100000000 << IDX_BITS);
        lnv = (lg * longint'(LN2_30)) / longint'(ONE30);
        v = (lnv * 64'sd17883277) / 64'sd100000000
          + longint'((64'd55991073 << 30) / 64'd100000000);
        if (v < 0) v = 0;
        hlg_curve[i] = ((longint'(v) << FB) + (ONE30 >> 1)) >> 30;
      end
    end
  endtask

  function automatic longint hlg_lookup(longint unsigned x);
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned fr;
    pos = x << IDX_BITS;
    idx = pos >> FB;
    fr = pos & ((64'd1 << FB) - 1);
    if (idx >= OETF_LEN - 1) return longint'(hlg_curve[OETF_LEN - 1]);
    return longint'((hlg_curve[idx] * ((64'd1 << FB) - fr) + hlg_curve[idx + 1] * fr
                     + (64'd1 << (FB - 1))) >> FB);
  endfunction

  function automatic logic [15:0] round_q88(longint x, longint off);
    longint num;
    num = x * Q88_MAX + off * (64'sd1 << (FB + 12)) + (64'sd1 << (FB + 11));
    if (num < 0) return 16'd0;
    num = num >>> (FB + 12);
    return (num > Q88_MAX) ? 16'(Q88_MAX) : 16'(num);
  endfunction

  function automatic pix_out_t ictcp_of(pix_in_t p);
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    longint lp;
    longint mp;
    longint sp;
    pix_out_t o;
    r = srgb_lin[p.red];
    g = srgb_lin[p.green];
    b = srgb_lin[p.blue];
    lp = hlg_lookup((C_L_R * r + C_L_G * g + C_L_B * b + 2048) >> MAT_SHIFT);
    mp = hlg_lookup((C_M_R * r + C_M_G * g + C_M_B * b + 2048) >> MAT_SHIFT);
    sp = hlg_lookup((C_S_R * r + C_S_G * g + C_S_B * b + 2048) >> MAT_SHIFT);
    o.intensity = round_q88(C_I_L * lp + C_I_M * mp, 0);
    o.tritan = round_q88(C_CT_L * lp - C_CT_M * mp + C_CT_S * sp, Q88_OFFSET);
    o.protan = round_q88(C_CP_L * lp - C_CP_M * mp - C_CP_S * sp, Q88_OFFSET);
    return o;
  endfunction

  function automatic pix_in_t mk_pix(int r, int g, int b);
    pix_in_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    return p;
  endfunction

  function automatic logic [7:0] rand_code();
    case ($urandom_range(9))
      0: return 8'($urandom_range(12));
      1: return 8'(255 - $urandom_range(3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // driver: a new transaction goes out once the previous one has been taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (pending_pix.size() > 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_pix.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    pix_out_t want;
    took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_ictcp.push_back(ictcp_of(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ictcp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failed = 1'b1;
      end else begin
        want = expected_ictcp.pop_front();
        if (out_data.intensity !== want.intensity) begin
          $display("%0t: intensity expected %h got %h", $time, want.intensity,
                   out_data.intensity);
          failed = 1'b1;
        end
        if (out_data.tritan !== want.tritan) begin
          $display("%0t: tritan expected %h got %h", $time, want.tritan, out_data.tritan);
          failed = 1'b1;
        end
        if (out_data.protan !== want.protan) begin
          $display("%0t: protan expected %h got %h", $time, want.protan, out_data.protan);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic drain();
    while (pending_pix.size() > 0 || in_valid || expected_ictcp.size() > 0) @(posedge clk);
  endtask

  initial begin
    failed = 1'b0;
    took = 1'b0;
    send_hold = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    build_curves();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corners: black, white, primaries, secondaries, linear segment edge, near full scale, mid tones
    pending_pix.push_back(mk_pix(0, 0, 0));
    pending_pix.push_back(mk_pix(255, 255, 255));
    pending_pix.push_back(mk_pix(255, 0, 0));
    pending_pix.push_back(mk_pix(0, 255, 0));
    pending_pix.push_back(mk_pix(0, 0, 255));
    pending_pix.push_back(mk_pix(255, 255, 0));
    pending_pix.push_back(mk_pix(0, 255, 255));
    pending_pix.push_back(mk_pix(255, 0, 255));
    pending_pix.push_back(mk_pix(10, 10, 10));
    pending_pix.push_back(mk_pix(11, 11, 11));
    pending_pix.push_back(mk_pix(1, 1, 1));
    pending_pix.push_back(mk_pix(10, 11, 12));
    pending_pix.push_back(mk_pix(254, 254, 254));
    pending_pix.push_back(mk_pix(170, 85, 170));
    pending_pix.push_back(mk_pix(85, 170, 85));
    pending_pix.push_back(mk_pix(128, 128, 128));
    pending_pix.push_back(mk_pix(255, 254, 0));
    pending_pix.push_back(mk_pix(0, 1, 255));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 48; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 48; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int k = 0; k < 175; k++)
        pending_pix.push_back(mk_pix(rand_code(), rand_code(), rand_code()));
      if (ph == 2) begin
        // hold the sender part way through until the pipe is empty
        while (pending_pix.size() > 90) @(posedge clk);
        send_hold = 1'b1;
        while (in_valid || expected_ictcp.size() > 0) @(posedge clk);
        send_hold = 1'b0;
      end
      drain();
    end
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (!failed && expected_ictcp.size() == 0) begin
      $display("[srgb8_to_ictcp_hlg] OK");
    end else begin
      $display("[srgb8_to_ictcp_hlg] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[srgb8_to_ictcp_hlg] ERROR");
    $finish;
  end

endmodule
